/* hw/rtl/boa_pkg.sv */
package boa_pkg;

	// Command codes of an input item.
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_CLAIM = 1'b1;

	// Status codes of a result item.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ADD_LATE = 2'd1;
	localparam logic [1:0] ST_OVER     = 2'd2;

	// Number of buckets that the 4-bit bucket field can reach.
	localparam int REACH_BUCKETS = 16;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic walk;
		logic add;
		logic sub;
	} boa_cell_ctrl_t;

endpackage

/* hw/rtl/boa_cell.sv */
module boa_cell import boa_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  boa_cell_ctrl_t         ctrl,
	input  logic [COUNT_WIDTH-1:0] left_end,
	input  logic [COUNT_WIDTH-1:0] operand,
	output logic [COUNT_WIDTH-1:0] end_val
);

	logic [COUNT_WIDTH-1:0] end_q;
	logic [COUNT_WIDTH-1:0] addend;
	logic [COUNT_WIDTH:0]   sum;
	logic [COUNT_WIDTH-1:0] sat_sum;

	// Saturating add of either the left neighbor (prefix walk) or the item count.
	always_comb begin
		addend  = ctrl.walk ? left_end : operand;
		sum     = {1'b0, end_q} + {1'b0, addend};
		sat_sum = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
	end

	// The bucket end held by this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_q <= '0;
		end else if (ctrl.walk || ctrl.add) begin
			end_q <= sat_sum;
		end else if (ctrl.sub) begin
			end_q <= end_q - operand;
		end
	end

	assign end_val = end_q;

endmodule

/* hw/rtl/bucket_offset_allocator.sv */
// Each accepted item passes through S_EXEC and S_FIN before its result is offered
// from the output register; the block takes no new item until the last one has left
// S_FIN. The first claim adds the prefix walk, one chain cell per cycle, along the row
// of bucket cells. A result that is still stalled when the next one is ready holds the
// block until it is taken. Reset (arst_n low) clears every bucket end, the prefix flag,
// base_index and the output register at once; the block leaves reset ready for items.
module bucket_offset_allocator import boa_pkg::*; #(
	parameter int NUM_BUCKETS = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        base_index_we,
	input  logic [31:0] base_index,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        cmd,
	input  logic [3:0]  bucket,
	input  logic [31:0] count,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [31:0] position,
	output logic [1:0]  status
);

	localparam int IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(NUM_BUCKETS - 1);

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_EXEC, S_FIN} state_t;

	state_t                 state_q;
	logic                   prefix_done_q;
	logic                   cmd_q;
	logic [3:0]             bkt_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [IDX_W-1:0]       step_q;
	logic [1:0]             exec_st_q;
	logic [31:0]            base_q;
	logic                   rsp_valid_q;
	logic [31:0]            position_q;
	logic [1:0]             status_q;

	logic [COUNT_WIDTH-1:0] cnt_in;
	logic [COUNT_WIDTH-1:0] cell_end [NUM_BUCKETS];
	logic [COUNT_WIDTH-1:0] sel_end  [REACH_BUCKETS];
	logic [COUNT_WIDTH-1:0] old_end;
	logic [31:0]            end32;
	logic                   bkt_ok;
	logic                   over;
	logic                   exec_add;
	logic                   exec_sub;
	logic [1:0]             exec_status;

	// Only the low COUNT_WIDTH bits of the count are used.
	generate
		if (COUNT_WIDTH >= 32) begin : g_cnt_wide
			assign cnt_in = COUNT_WIDTH'(count);
		end else begin : g_cnt_narrow
			assign cnt_in = count[COUNT_WIDTH-1:0];
		end
	endgenerate

	// Row of bucket cells; each one sees its left neighbor for the prefix walk.
	generate
		for (genvar i = 0; i < NUM_BUCKETS; i++) begin : g_cell
			localparam bit REACH = (i < REACH_BUCKETS);
			boa_cell_ctrl_t         ctrl;
			logic [COUNT_WIDTH-1:0] left;

			if (i == 0) begin : g_first
				assign left = '0;
			end else begin : g_rest
				assign left = cell_end[i-1];
			end

			assign ctrl.walk = (state_q == S_WALK) && (step_q == IDX_W'(i));
			assign ctrl.add  = exec_add && REACH && (bkt_q == 4'(i));
			assign ctrl.sub  = exec_sub && REACH && (bkt_q == 4'(i));

			boa_cell #(
				.COUNT_WIDTH(COUNT_WIDTH)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl),
				.left_end(left),
				.operand (cnt_q),
				.end_val (cell_end[i])
			);
		end
	endgenerate

	// Selection over the buckets that the bucket field can address.
	generate
		for (genvar j = 0; j < REACH_BUCKETS; j++) begin : g_sel
			if (j < NUM_BUCKETS) begin : g_on
				assign sel_end[j] = cell_end[j];
			end else begin : g_off
				assign sel_end[j] = '0;
			end
		end
	endgenerate

	assign old_end = sel_end[bkt_q];

	generate
		if (COUNT_WIDTH >= 32) begin : g_end_wide
			assign end32 = old_end[31:0];
		end else begin : g_end_narrow
			assign end32 = 32'(old_end);
		end
	endgenerate

	// Decode of the item under execution.
	always_comb begin
		bkt_ok   = (int'(bkt_q) < NUM_BUCKETS);
		over     = (cnt_q > old_end);
		exec_add = (state_q == S_EXEC) && (cmd_q == CMD_ADD) && !prefix_done_q && bkt_ok;
		exec_sub = (state_q == S_EXEC) && (cmd_q == CMD_CLAIM) && bkt_ok && !over;
		case (cmd_q)
			CMD_ADD:   exec_status = prefix_done_q ? ST_ADD_LATE : ST_OK;
			default:   exec_status = (!bkt_ok || over) ? ST_OVER : ST_OK;
		endcase
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (base_index_we) begin
			base_q <= base_index;
		end
	end

	// Sequencer with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			prefix_done_q <= 1'b0;
			cmd_q         <= CMD_ADD;
			bkt_q         <= '0;
			cnt_q         <= '0;
			step_q        <= '0;
			exec_st_q     <= ST_OK;
			rsp_valid_q   <= 1'b0;
			position_q    <= '0;
			status_q      <= ST_OK;
		end else begin
			// A taken result clears the output; in S_FIN the new result replaces it.
			if (rsp_valid_q && !rsp_stall && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cmd_q <= cmd;
						bkt_q <= bucket;
						cnt_q <= cnt_in;
						if (cmd == CMD_CLAIM && !prefix_done_q) begin
							prefix_done_q <= 1'b1;
							if (NUM_BUCKETS > 1) begin
								step_q  <= IDX_W'(1);
								state_q <= S_WALK;
							end else begin
								state_q <= S_EXEC;
							end
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_WALK: begin
					if (step_q == LAST_STEP) begin
						state_q <= S_EXEC;
					end else begin
						step_q <= step_q + IDX_W'(1);
					end
				end
				S_EXEC: begin
					exec_st_q <= exec_status;
					state_q   <= S_FIN;
				end
				S_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						status_q    <= exec_st_q;
						if (cmd_q == CMD_CLAIM && exec_st_q == ST_OK) begin
							position_q <= base_q + end32;
						end else begin
							position_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign position  = position_q;
	assign status    = status_q;

endmodule
